// ===== src/bfgl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfgl_pkg
// Shared types and constants for the bitmap font glyph layout block.
// ----------------------------------------------------------------------------
package bfgl_pkg;

    localparam int GLYPH_COUNT_DEF = 256;
    localparam int COORD_BITS_DEF  = 16;

    localparam int FIELD_W    = 16;   // width of every result field
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 96;
    localparam int DIV_STEPS  = 8;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    // opcodes
    localparam logic [1:0] OP_LOAD_WIDTH = 2'd0;
    localparam logic [1:0] OP_START      = 2'd1;
    localparam logic [1:0] OP_PLACE      = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_GLYPH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_KERNING      = 3'd6;

    // reset values of the configuration registers
    localparam logic [7:0]  RST_FIRST_GLYPH  = 8'd32;
    localparam logic [7:0]  RST_CELL_WIDTH   = 8'd16;
    localparam logic [7:0]  RST_CELL_HEIGHT  = 8'd16;
    localparam logic [7:0]  RST_GRID_COLUMNS = 8'd16;
    localparam logic [11:0] RST_SCALE        = 12'd256;
    localparam logic [7:0]  RST_KERNING      = 8'd0;

    typedef enum logic [2:0] {
        KIND_IGNORE,
        KIND_LOAD,
        KIND_START,
        KIND_NEWLINE,
        KIND_GLYPH
    } item_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_MUL,
        ST_PEN,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic latch_in;
        logic tbl_wr;
        logic load_start;
        logic div_init;
        logic div_step;
        logic mul_en;
        logic newline_upd;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        item_kind_t kind;
        logic       out_free;
    } dp_status_t;

endpackage

// ===== src/bfgl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfgl_ctrl
// Sequencer: accepts one item, steps the datapath through decode and, as the
// item needs, divide, multiply and result/pen update, then returns to idle.
// ----------------------------------------------------------------------------
module bfgl_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  bfgl_pkg::dp_status_t status,
    output bfgl_pkg::dp_cmd_t    cmd
);

    bfgl_pkg::ctrl_state_t state_reg, state_next;
    logic [bfgl_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bfgl_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            bfgl_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = bfgl_pkg::ST_DECODE;
                end
            end
            bfgl_pkg::ST_DECODE: begin
                case (status.kind)
                    bfgl_pkg::KIND_LOAD: begin
                        cmd.tbl_wr = 1'b1;
                        state_next = bfgl_pkg::ST_IDLE;
                    end
                    bfgl_pkg::KIND_START: begin
                        cmd.load_start = 1'b1;
                        state_next     = bfgl_pkg::ST_IDLE;
                    end
                    bfgl_pkg::KIND_NEWLINE: begin
                        state_next = bfgl_pkg::ST_MUL;
                    end
                    bfgl_pkg::KIND_GLYPH: begin
                        cmd.div_init = 1'b1;
                        cnt_next     = '0;
                        state_next   = bfgl_pkg::ST_DIV;
                    end
                    default: begin
                        state_next = bfgl_pkg::ST_IDLE;
                    end
                endcase
            end
            bfgl_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == bfgl_pkg::CNT_W'(bfgl_pkg::DIV_STEPS - 1)) begin
                    state_next = bfgl_pkg::ST_MUL;
                end
            end
            bfgl_pkg::ST_MUL: begin
                cmd.mul_en = 1'b1;
                if (status.kind == bfgl_pkg::KIND_NEWLINE) begin
                    state_next = bfgl_pkg::ST_PEN;
                end else begin
                    state_next = bfgl_pkg::ST_EMIT;
                end
            end
            bfgl_pkg::ST_PEN: begin
                cmd.newline_upd = 1'b1;
                state_next      = bfgl_pkg::ST_IDLE;
            end
            bfgl_pkg::ST_EMIT: begin
                // hold until the output register can take the result
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = bfgl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bfgl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/bfgl_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfgl_datapath
// Configuration registers, width table, restoring divider, products, pen
// registers with saturation and the output register.
// ----------------------------------------------------------------------------
module bfgl_datapath #(
    parameter int GLYPH_COUNT = bfgl_pkg::GLYPH_COUNT_DEF,
    parameter int COORD_BITS  = bfgl_pkg::COORD_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [bfgl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bfgl_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [1:0]                          in_opcode,
    input  logic [7:0]                          in_char_code,
    input  logic [7:0]                          in_glyph_width,
    input  logic signed [bfgl_pkg::FIELD_W-1:0] in_start_x,
    input  logic signed [bfgl_pkg::FIELD_W-1:0] in_start_y,
    input  bfgl_pkg::dp_cmd_t                   cmd,
    output bfgl_pkg::dp_status_t                status,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic signed [bfgl_pkg::FIELD_W-1:0] out_dest_x,
    output logic signed [bfgl_pkg::FIELD_W-1:0] out_dest_y,
    output logic [bfgl_pkg::FIELD_W-1:0]        out_src_left,
    output logic [bfgl_pkg::FIELD_W-1:0]        out_src_top,
    output logic [bfgl_pkg::FIELD_W-1:0]        out_src_right,
    output logic [bfgl_pkg::FIELD_W-1:0]        out_src_bottom
);

    localparam int IDX_W = $clog2(GLYPH_COUNT);
    localparam int CW    = COORD_BITS;
    // wide enough for pen + kerning + largest advance, and for a 16-bit start
    localparam int SW    = ((CW > 14) ? CW : 14) + 2;
    localparam logic signed [SW-1:0] PEN_HI = SW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] PEN_LO = -PEN_HI - SW'(1);
    localparam logic [8:0] GLYPH_LIMIT = 9'(GLYPH_COUNT);

    // configuration
    logic [7:0]        first_glyph_reg, cell_width_reg, cell_height_reg, grid_cols_reg;
    logic [11:0]       scale_x_reg, scale_y_reg;
    logic signed [7:0] kerning_reg;

    // latched item
    logic [1:0]        op_reg;
    logic [7:0]        code_reg, gwidth_reg;
    logic signed [15:0] start_x_reg, start_y_reg;

    // width table
    logic [7:0] width_mem [GLYPH_COUNT];
    logic [7:0] width_rd_reg;

    // divider
    logic [7:0] rem_reg, quo_reg;
    logic [7:0] cols;
    logic [8:0] rem_shift;
    logic [8:0] rem_diff;

    // products
    logic [15:0] left_reg, top_reg;
    logic [11:0] dx_reg, dy_reg;
    logic [15:0] prod_left, prod_top;
    logic [19:0] prod_dx, prod_dy;

    // pen
    logic signed [CW-1:0] pen_x_reg, pen_y_reg, line_start_reg;
    logic signed [SW-1:0] pen_x_ext, pen_y_ext, adv_x_sum, adv_y_sum;

    logic out_valid_reg;
    logic in_range;

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        begin
            if (v > PEN_HI) begin
                r = PEN_HI;
            end else if (v < PEN_LO) begin
                r = PEN_LO;
            end else begin
                r = v;
            end
            return r[CW-1:0];
        end
    endfunction

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_glyph_reg <= bfgl_pkg::RST_FIRST_GLYPH;
            cell_width_reg  <= bfgl_pkg::RST_CELL_WIDTH;
            cell_height_reg <= bfgl_pkg::RST_CELL_HEIGHT;
            grid_cols_reg   <= bfgl_pkg::RST_GRID_COLUMNS;
            scale_x_reg     <= bfgl_pkg::RST_SCALE;
            scale_y_reg     <= bfgl_pkg::RST_SCALE;
            kerning_reg     <= bfgl_pkg::RST_KERNING;
        end else if (cfg_we) begin
            case (cfg_index)
                bfgl_pkg::REG_FIRST_GLYPH:  first_glyph_reg <= cfg_data[7:0];
                bfgl_pkg::REG_CELL_WIDTH:   cell_width_reg  <= cfg_data[7:0];
                bfgl_pkg::REG_CELL_HEIGHT:  cell_height_reg <= cfg_data[7:0];
                bfgl_pkg::REG_GRID_COLUMNS: grid_cols_reg   <= cfg_data[7:0];
                bfgl_pkg::REG_SCALE_X:      scale_x_reg     <= cfg_data;
                bfgl_pkg::REG_SCALE_Y:      scale_y_reg     <= cfg_data;
                bfgl_pkg::REG_KERNING:      kerning_reg     <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // latch the accepted item
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            op_reg      <= in_opcode;
            code_reg    <= in_char_code;
            gwidth_reg  <= in_glyph_width;
            start_x_reg <= in_start_x;
            start_y_reg <= in_start_y;
        end
    end

    // classify the latched item
    assign in_range = {1'b0, code_reg} < GLYPH_LIMIT;

    always_comb begin
        status.kind     = bfgl_pkg::KIND_IGNORE;
        status.out_free = !out_valid_reg || m_tready;
        case (op_reg)
            bfgl_pkg::OP_LOAD_WIDTH: begin
                if (in_range) status.kind = bfgl_pkg::KIND_LOAD;
            end
            bfgl_pkg::OP_START: begin
                status.kind = bfgl_pkg::KIND_START;
            end
            bfgl_pkg::OP_PLACE: begin
                if (code_reg == bfgl_pkg::NEWLINE_CODE) begin
                    status.kind = bfgl_pkg::KIND_NEWLINE;
                end else if (in_range && code_reg >= first_glyph_reg) begin
                    status.kind = bfgl_pkg::KIND_GLYPH;
                end
            end
            default: status.kind = bfgl_pkg::KIND_IGNORE;
        endcase
    end

    // width table: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.tbl_wr) begin
            width_mem[code_reg[IDX_W-1:0]] <= gwidth_reg;
        end
        width_rd_reg <= width_mem[code_reg[IDX_W-1:0]];
    end

    // restoring divide: offset / cols, one quotient bit per step
    assign cols      = (grid_cols_reg == 8'd0) ? 8'd1 : grid_cols_reg;
    assign rem_shift = {rem_reg, quo_reg[7]};
    assign rem_diff  = rem_shift - {1'b0, cols};

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            rem_reg <= '0;
            quo_reg <= code_reg - first_glyph_reg;
        end else if (cmd.div_step) begin
            if (rem_shift >= {1'b0, cols}) begin
                rem_reg <= rem_diff[7:0];
                quo_reg <= {quo_reg[6:0], 1'b1};
            end else begin
                rem_reg <= rem_shift[7:0];
                quo_reg <= {quo_reg[6:0], 1'b0};
            end
        end
    end

    // products, truncated Q4.8 scaling
    assign prod_left = cell_width_reg * rem_reg;
    assign prod_top  = cell_height_reg * quo_reg;
    assign prod_dx   = width_rd_reg * scale_x_reg;
    assign prod_dy   = cell_height_reg * scale_y_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            left_reg <= prod_left;
            top_reg  <= prod_top;
            dx_reg   <= prod_dx[19:8];
            dy_reg   <= prod_dy[19:8];
        end
    end

    // pen arithmetic
    assign pen_x_ext = SW'(pen_x_reg);
    assign pen_y_ext = SW'(pen_y_reg);
    assign adv_x_sum = pen_x_ext + SW'(kerning_reg) + $signed(SW'(dx_reg));
    assign adv_y_sum = pen_y_ext + $signed(SW'(dy_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_x_reg      <= '0;
            pen_y_reg      <= '0;
            line_start_reg <= '0;
        end else if (cmd.load_start) begin
            pen_x_reg      <= sat_coord(SW'(start_x_reg));
            pen_y_reg      <= sat_coord(SW'(start_y_reg));
            line_start_reg <= sat_coord(SW'(start_x_reg));
        end else if (cmd.newline_upd) begin
            pen_x_reg <= line_start_reg;
            pen_y_reg <= sat_coord(adv_y_sum);
        end else if (cmd.emit) begin
            pen_x_reg <= sat_coord(adv_x_sum);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_dest_x     <= pen_x_ext[15:0];
            out_dest_y     <= pen_y_ext[15:0];
            out_src_left   <= left_reg;
            out_src_top    <= top_reg;
            out_src_right  <= left_reg + {8'd0, width_rd_reg};
            out_src_bottom <= top_reg + {8'd0, cell_height_reg};
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ===== src/bitmap_font_glyph_layout.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_font_glyph_layout
// Text layout for a grid-packed bitmap font: glyph width table, pen tracking
// and source cell rectangle per placed character.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries commands: load a glyph width, start a string at a pen
//   position, or place a character. A placed character in the font range
//   produces one m_ transfer with the destination pen and source rectangle;
//   newline, width loads, string starts and skipped codes produce none.
//   The user writes configuration via cfg_we/cfg_index/cfg_data only while idle;
//   the block itself does not enforce this.
// Timing:
//   One item at a time. Width loads and string starts pass accept and decode;
//   newline adds multiply and pen update; a placed glyph passes accept, decode/table
//   read, 8 steps of the bit-serial row/column divider, multiply and result. The
//   result lands in an output register, so the next item is accepted while it waits.
// Reset:
//   aresetn (synchronous, active low) clears the pen, the line start and the
//   channel state and restores register defaults. The width table is not
//   cleared. A stalled m_ side holds the result; a following glyph waits in
//   its result state until the output register frees up.
// ----------------------------------------------------------------------------
module bitmap_font_glyph_layout #(
    parameter int GLYPH_COUNT = bfgl_pkg::GLYPH_COUNT_DEF,
    parameter int COORD_BITS  = bfgl_pkg::COORD_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [bfgl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bfgl_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // opcode[1:0], char_code[9:2], glyph_width[17:10], start_x[33:18],
    // start_y[49:34], zero fill above
    input  logic [bfgl_pkg::S_TDATA_W-1:0]       s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // dest_x[15:0], dest_y[31:16], src_left[47:32], src_top[63:48],
    // src_right[79:64], src_bottom[95:80]
    output logic [bfgl_pkg::M_TDATA_W-1:0]       m_tdata
);

    bfgl_pkg::dp_cmd_t    cmd;
    bfgl_pkg::dp_status_t status;

    logic signed [bfgl_pkg::FIELD_W-1:0] dest_x, dest_y;
    logic [bfgl_pkg::FIELD_W-1:0]        src_left, src_top, src_right, src_bottom;

    bfgl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bfgl_datapath #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .COORD_BITS  (COORD_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_opcode      (s_tdata[1:0]),
        .in_char_code   (s_tdata[9:2]),
        .in_glyph_width (s_tdata[17:10]),
        .in_start_x     (s_tdata[33:18]),
        .in_start_y     (s_tdata[49:34]),
        .cmd            (cmd),
        .status         (status),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .out_dest_x     (dest_x),
        .out_dest_y     (dest_y),
        .out_src_left   (src_left),
        .out_src_top    (src_top),
        .out_src_right  (src_right),
        .out_src_bottom (src_bottom)
    );

    assign m_tdata = {src_bottom, src_right, src_top, src_left, dest_y, dest_x};

endmodule
